>>> design/lcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_pkg: shared types and constants for the length/checksum deframer
// Result record passed from the frame parser to the output queue, and sizes.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DATA_W  = 32;

  typedef struct packed {
    logic              is_status;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_payload;
    logic              checksum_ok;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage
`default_nettype wire

>>> design/length_checksum_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// A payload or status result is queued when the byte that causes it is
// transferred in, behind older results; header bytes give no result.
// Throughput: one byte per cycle, limited only by the four-entry result queue
// filling when the output side stalls.
// Reset (rst, synchronous): parser returns to the length high byte, queue empties.
// ----------------------------------------------------------------------------
// length_checksum_deframer: length-prefixed frame deframer, 16-bit checksum
// Passes payload bytes through with a last mark, then a checksum status.
// ----------------------------------------------------------------------------
module length_checksum_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [lcd_pkg::BYTE_W-1:0]      s_tdata,  // [7:0] frame_byte
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] payload_byte, [8] checksum_ok, [24:9] frame_length, rest zero
  output logic [lcd_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic                                 m_tlast,  // last_payload
  output logic [0:0]                           m_tuser   // [0] is_status
);

  logic             res_valid;
  logic             room;
  lcd_pkg::result_t res;
  lcd_pkg::result_t head;

  lcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .room      (room),
    .res_valid (res_valid),
    .res       (res)
  );

  lcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  assign m_tdata = {{(lcd_pkg::OUT_DATA_W - lcd_pkg::LEN_W - 1 - lcd_pkg::BYTE_W){1'b0}},
                    head.frame_length, head.checksum_ok, head.payload_byte};
  assign m_tlast = head.last_payload;
  assign m_tuser = head.is_status;

endmodule
`default_nettype wire

>>> design/lcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_front: frame parser
// Tracks the frame phase, length, remaining count and running sum, and
// turns each accepted byte into zero or one result record.
// ----------------------------------------------------------------------------
module lcd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [lcd_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       room,
  output logic                            res_valid,
  output lcd_pkg::result_t                res
);

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CHK_LO  = 3'd3,
    PH_CHK_HI  = 3'd4
  } phase_t;

  phase_t                       phase;
  logic [lcd_pkg::LEN_W-1:0]    length_value;
  logic [lcd_pkg::LEN_W-1:0]    bytes_remaining;
  logic [lcd_pkg::LEN_W-1:0]    running_sum;
  logic [lcd_pkg::BYTE_W-1:0]   checksum_low;

  logic                         in_fire;
  logic [lcd_pkg::LEN_W-1:0]    sum_add;
  logic [lcd_pkg::LEN_W-1:0]    len_full;
  logic                         final_byte;

  assign in_ready   = room;
  assign in_fire    = in_valid && in_ready;
  assign sum_add    = running_sum + {{(lcd_pkg::LEN_W-lcd_pkg::BYTE_W){1'b0}}, in_byte};
  assign len_full   = {length_value[lcd_pkg::LEN_W-1:lcd_pkg::BYTE_W], in_byte};
  // Remaining count of one or less marks the final payload byte.
  assign final_byte = (bytes_remaining[lcd_pkg::LEN_W-1:1] == '0);

  always_comb begin
    res_valid        = 1'b0;
    res              = '0;
    case (phase)
      PH_PAYLOAD: begin
        res_valid        = in_fire;
        res.payload_byte = in_byte;
        res.last_payload = final_byte;
      end
      PH_CHK_HI: begin
        res_valid        = in_fire;
        res.is_status    = 1'b1;
        res.checksum_ok  = ({in_byte, checksum_low} == running_sum);
        res.frame_length = length_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_HI;
      length_value    <= '0;
      bytes_remaining <= '0;
      running_sum     <= '0;
      checksum_low    <= '0;
    end else if (in_fire) begin
      case (phase)
        PH_LEN_LO: begin
          length_value    <= len_full;
          bytes_remaining <= len_full;
          running_sum     <= sum_add;
          phase           <= (len_full == '0) ? PH_CHK_LO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_sum <= sum_add;
          if (final_byte) begin
            bytes_remaining <= '0;
            phase           <= PH_CHK_LO;
          end else begin
            bytes_remaining <= bytes_remaining - 1'b1;
          end
        end
        PH_CHK_LO: begin
          checksum_low <= in_byte;
          phase        <= PH_CHK_HI;
        end
        PH_CHK_HI: begin
          phase           <= PH_LEN_HI;
          length_value    <= '0;
          bytes_remaining <= '0;
          running_sum     <= '0;
          checksum_low    <= '0;
        end
        default: begin
          length_value    <= {in_byte, {lcd_pkg::BYTE_W{1'b0}}};
          bytes_remaining <= '0;
          running_sum     <= {{(lcd_pkg::LEN_W-lcd_pkg::BYTE_W){1'b0}}, in_byte};
          checksum_low    <= '0;
          phase           <= PH_LEN_LO;
        end
      endcase
    end
  end

  a_status_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_CHK_HI |=> phase == PH_LEN_HI && running_sum == '0)
    else $error("frame state not cleared after status");

  a_last_to_checksum: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_PAYLOAD && final_byte |=> phase == PH_CHK_LO)
    else $error("final payload byte did not move to checksum");

  a_payload_nonzero_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> length_value != '0)
    else $error("payload phase with zero length");

endmodule
`default_nettype wire

>>> design/lcd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_queue: result queue and output side
// Small register queue that holds parsed results until the consumer takes
// them, so the parser keeps accepting bytes while the output stalls, until it fills.
// ----------------------------------------------------------------------------
module lcd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lcd_pkg::result_t push_data,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lcd_pkg::result_t      out_data
);

  lcd_pkg::result_t              slots [lcd_pkg::QUEUE_DEPTH];
  logic [lcd_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [lcd_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [lcd_pkg::QUEUE_CW-1:0]  count;
  logic                          pop;

  assign room      = (count != lcd_pkg::QUEUE_CW'(lcd_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lcd_pkg::QUEUE_AW'(lcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lcd_pkg::QUEUE_AW'(lcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room || pop)
    else $error("result pushed into a full queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule
`default_nettype wire

>>> verif/tb_length_checksum_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_checksum_deframer: self-checking bench for the frame deframer
// Feeds length-prefixed frames with good and corrupted checksums, predicts
// every payload and status transfer, and compares each output transfer in
// order. Both stream sides idle at random in shifting proportions.
// ----------------------------------------------------------------------------
module tb_length_checksum_deframer;

  typedef enum logic [2:0] {
    WAIT_LEN_HI  = 3'd0,
    WAIT_LEN_LO  = 3'd1,
    IN_PAYLOAD   = 3'd2,
    WAIT_CHK_LO  = 3'd3,
    WAIT_CHK_HI  = 3'd4
  } parse_phase_t;

  typedef enum int {
    FILL_RANDOM = 0,
    FILL_ONES   = 1,
    FILL_ZEROS  = 2
  } payload_fill_t;

  // Tracks the parser state of the deframer and holds the transfers it owes.
  class frame_scoreboard;
    parse_phase_t      phase;
    logic [15:0]       hdr_len;
    logic [15:0]       remaining;
    logic [15:0]       sum;
    logic [7:0]        chk_lo;
    lcd_pkg::result_t  owed_q[$];
    int                errors;

    function new();
      phase     = WAIT_LEN_HI;
      hdr_len   = '0;
      remaining = '0;
      sum       = '0;
      chk_lo    = '0;
      errors    = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      lcd_pkg::result_t r;
      r = '0;
      case (phase)
        WAIT_LEN_LO: begin
          hdr_len   = hdr_len | {8'h00, b};
          remaining = hdr_len;
          sum       = sum + {8'h00, b};
          phase     = (hdr_len == 16'd0) ? WAIT_CHK_LO : IN_PAYLOAD;
        end
        IN_PAYLOAD: begin
          sum            = sum + {8'h00, b};
          r.payload_byte = b;
          r.last_payload = (remaining <= 16'd1);
          owed_q.push_back(r);
          if (remaining <= 16'd1) begin
            remaining = '0;
            phase     = WAIT_CHK_LO;
          end else begin
            remaining = remaining - 16'd1;
          end
        end
        WAIT_CHK_LO: begin
          chk_lo = b;
          phase  = WAIT_CHK_HI;
        end
        WAIT_CHK_HI: begin
          r.is_status    = 1'b1;
          r.checksum_ok  = ({b, chk_lo} == sum);
          r.frame_length = hdr_len;
          owed_q.push_back(r);
          phase     = WAIT_LEN_HI;
          hdr_len   = '0;
          remaining = '0;
          sum       = '0;
          chk_lo    = '0;
        end
        default: begin
          hdr_len   = {b, 8'h00};
          remaining = '0;
          sum       = {8'h00, b};
          chk_lo    = '0;
          phase     = WAIT_LEN_LO;
        end
      endcase
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [lcd_pkg::OUT_DATA_W-1:0] data, logic last,
                               logic status);
      lcd_pkg::result_t w;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual data %0h last %0b user %0b",
                 $time, data, last, status);
        return;
      end
      w = owed_q.pop_front();
      compare("is_status", 32'(w.is_status), 32'(status));
      compare("payload_byte", 32'(w.payload_byte), 32'(data[7:0]));
      compare("last_payload", 32'(w.last_payload), 32'(last));
      compare("checksum_ok", 32'(w.checksum_ok), 32'(data[8]));
      compare("frame_length", 32'(w.frame_length), 32'(data[24:9]));
      compare("tdata padding", 32'd0, 32'(data[31:25]));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [lcd_pkg::BYTE_W-1:0]     s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [lcd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;
  logic [0:0]                     m_tuser;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 72;

  frame_scoreboard sb = new();

  length_checksum_deframer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tlast, m_tuser[0]);
    end
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows the transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  // The checksum flip mask corrupts the trailer; zero sends a good frame.
  task automatic send_frame(input int len, input payload_fill_t fill,
                            input logic [15:0] chk_flip);
    logic [15:0] csum;
    logic [15:0] frame_len;
    logic [7:0]  b;
    int          i;
    frame_len = 16'(len);
    csum = {8'h00, frame_len[15:8]} + {8'h00, frame_len[7:0]};
    send_byte(frame_len[15:8]);
    send_byte(frame_len[7:0]);
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom_range(255));
      endcase
      csum = csum + {8'h00, b};
      send_byte(b);
    end
    csum = csum ^ chk_flip;
    send_byte(csum[7:0]);
    send_byte(csum[15:8]);
  endtask

  task automatic run_random_frames(input int byte_budget);
    int            sent;
    int            len;
    int unsigned   pick;
    payload_fill_t fill;
    logic [15:0]   flip;
    sent = 0;
    while (sent < byte_budget) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = 0;
      else if (pick < 80) len = $urandom_range(16, 1);
      else if (pick < 95) len = $urandom_range(64, 17);
      else                len = $urandom_range(400, 200);
      pick = $urandom_range(99);
      if (pick < 10)      fill = FILL_ONES;
      else if (pick < 15) fill = FILL_ZEROS;
      else                fill = FILL_RANDOM;
      flip = ($urandom_range(99) < 20) ? 16'($urandom_range(65535, 1)) : 16'h0000;
      send_frame(len, fill, flip);
      sent += len + 4;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty frames, single-byte extremes, each trailer byte wrong.
    send_frame(0, FILL_ZEROS, 16'h0000);
    send_frame(0, FILL_ZEROS, 16'h8000);
    send_frame(1, FILL_ONES, 16'h0000);
    send_frame(1, FILL_ZEROS, 16'h0001);
    send_frame(3, FILL_RANDOM, 16'h0100);
    send_frame(2, FILL_RANDOM, 16'h0000);

    run_random_frames(520);

    send_idle_pct = 72;
    recv_idle_pct = 35;
    run_random_frames(520);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long all-ones frame: the running sum wraps past 16 bits.
    send_frame(300, FILL_ONES, 16'h0000);
    run_random_frames(520);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_length_checksum_deframer: clean");
    end else begin
      $display("tb_length_checksum_deframer: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("tb_length_checksum_deframer: errors");
    $finish;
  end

endmodule
